FILE: rtl/core/rgbw_led_strip_pwm_encoder_assert.svh
// Assertion shorthands for the LED strip encoder.
`ifndef RGBW_LED_STRIP_PWM_ENCODER_ASSERT_SVH
`define RGBW_LED_STRIP_PWM_ENCODER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define RLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define RLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rgbw_enc_pkg.sv
`default_nettype none

package rgbw_enc_pkg;

  // Store depth default and small queue between front and back
  localparam int unsigned MAX_LEDS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD      = 2'd0,
    CFG_USE_WHITE   = 2'd1,
    CFG_RESET_SLOTS = 2'd2,
    CFG_LED_COUNT   = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] PERIOD_RST      = 16'd104;
  localparam logic        USE_WHITE_RST   = 1'b1;
  localparam logic [7:0]  RESET_SLOTS_RST = 8'd40;
  localparam logic [8:0]  LED_COUNT_RST   = 9'd8;

  // Bits sent per LED
  localparam logic [5:0] BITS_RGBW = 6'd32;
  localparam logic [5:0] BITS_RGB  = 6'd24;

  // Divide by three: x * ceil(2^19 / 3) >> 19, exact for 17-bit x
  localparam logic [17:0] THIRD_MUL   = 18'h2AAAB;
  localparam int unsigned THIRD_SHIFT = 19;

  typedef enum logic [1:0] {
    MODE_WRITE_ONE = 2'd0,
    MODE_WRITE_ALL = 2'd1,
    MODE_START     = 2'd2,
    MODE_TICK      = 2'd3
  } mode_e;

  typedef struct packed {
    logic [15:0] period;
    logic        use_white;
    logic [7:0]  reset_slots;
    logic [8:0]  led_count;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] duty;
    logic        duty_valid;
    logic        busy_res;
    logic        frame_done;
  } out_item_t;

  // Classified command; color is kept in send order {G, R, B, W}
  typedef struct packed {
    mode_e       mode;
    logic        in_range;
    logic [7:0]  led_index;
    logic [31:0] color;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } status_t;

  function automatic logic [15:0] div3(input logic [16:0] x);
    logic [34:0] prod;
    begin
      prod = 35'(x) * 35'(THIRD_MUL);
      return 16'(prod >> THIRD_SHIFT);
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgbw_enc_in_if.sv
`default_nettype none

interface rgbw_enc_in_if;
  import rgbw_enc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rgbw_enc_out_if.sv
`default_nettype none

interface rgbw_enc_out_if;
  import rgbw_enc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rgbw_enc_front.sv
`default_nettype none

module rgbw_enc_front #(
  parameter int unsigned MAX_LEDS = rgbw_enc_pkg::MAX_LEDS_DEF
) (
  rgbw_enc_in_if.sink                          item,
  input  rgbw_enc_pkg::status_t                status_i,
  input  logic [((MAX_LEDS + 1 > 512) ? $clog2(MAX_LEDS + 1) : 9)-1:0] eff_count_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output rgbw_enc_pkg::cmd_t                   push_cmd_o
);
  import rgbw_enc_pkg::*;

  localparam int unsigned CntW = (MAX_LEDS + 1 > 512) ? $clog2(MAX_LEDS + 1) : 9;

  // Take a beat whenever the queue has room and the store is not being cleared
  assign item.ready = !full_i && !status_i.clearing;
  assign push_o     = item.valid && item.ready;

  // Classify: range check for single writes, repack color in send order
  always_comb begin
    push_cmd_o.mode      = item.data.mode;
    push_cmd_o.led_index = item.data.led_index;
    push_cmd_o.in_range  = CntW'(item.data.led_index) < eff_count_i;
    push_cmd_o.color     = {item.data.green, item.data.red, item.data.blue, item.data.white};
  end

endmodule

`default_nettype wire

FILE: rtl/core/rgbw_enc_queue.sv
`default_nettype none

module rgbw_enc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rgbw_enc_pkg::cmd_t push_cmd_i,
  input  logic               pop_i,
  output rgbw_enc_pkg::cmd_t head_o,
  output logic               empty_o,
  output logic               full_o
);
  import rgbw_enc_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rgbw_enc_back.sv
`default_nettype none

module rgbw_enc_back #(
  parameter int unsigned MAX_LEDS = rgbw_enc_pkg::MAX_LEDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbw_enc_pkg::cfg_t    cfg_i,
  input  logic [((MAX_LEDS + 1 > 512) ? $clog2(MAX_LEDS + 1) : 9)-1:0] eff_count_i,
  input  rgbw_enc_pkg::cmd_t    head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output rgbw_enc_pkg::status_t status_o,
  rgbw_enc_out_if.source        result
);
  import rgbw_enc_pkg::*;

  localparam int unsigned IdxW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CntW = (MAX_LEDS + 1 > 512) ? $clog2(MAX_LEDS + 1) : 9;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_END
  } phase_e;

  // Result stage: everything but the stored bit, which comes from the read port
  typedef struct packed {
    logic        accepted;
    logic        duty_valid;
    logic        busy;
    logic        done;
    logic        use_mem;
    logic [4:0]  bsel;
    logic [15:0] fix;
    logic [15:0] hi;
    logic [15:0] lo;
  } stage_t;

  // Frame sequencer state
  phase_e            phase_q, phase_d;
  logic              busy_q, busy_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [4:0]        bit_q, bit_d;
  logic [7:0]        slot_q, slot_d;

  // Store sweep (clear pass after reset, write-all)
  logic              init_q, init_d;
  logic              sweep_q, sweep_d;
  logic [CntW-1:0]   sweep_addr_q, sweep_addr_d;
  logic [CntW-1:0]   sweep_end_q, sweep_end_d;
  logic [31:0]       sweep_data_q, sweep_data_d;

  // Output stage
  logic              b_valid_q, b_valid_d;
  stage_t            b_q, b_d;

  // Color store
  logic [31:0]       mem_q [MAX_LEDS];
  logic [31:0]       rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  logic              fire;
  logic [5:0]        nbits;
  logic [7:0]        slots_eff;
  logic [15:0]       duty_half, duty_lo, duty_hi;

  assign fire      = !empty_i && !sweep_q && (!b_valid_q || result.ready);
  assign pop_o     = fire;
  assign status_o.clearing = init_q;

  assign nbits     = cfg_i.use_white ? BITS_RGBW : BITS_RGB;
  assign slots_eff = (cfg_i.reset_slots == 8'd0) ? 8'd1 : cfg_i.reset_slots;
  assign duty_half = cfg_i.period >> 1;
  assign duty_lo   = div3({1'b0, cfg_i.period});
  assign duty_hi   = div3({cfg_i.period, 1'b0});

  // Execute the head command
  always_comb begin
    logic [CntW-1:0] lp;
    logic [CntW-1:0] lp_nx;
    logic [4:0]      bp;
    logic [5:0]      bp_nx;
    logic [7:0]      slot_in;
    logic [7:0]      slot_nx;
    logic            go_end;

    phase_d      = phase_q;
    busy_d       = busy_q;
    ptr_d        = ptr_q;
    bit_d        = bit_q;
    slot_d       = slot_q;
    init_d       = init_q;
    sweep_d      = sweep_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    sweep_data_d = sweep_data_q;
    b_valid_d    = b_valid_q && !result.ready;
    b_d          = b_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = sweep_addr_q[IdxW-1:0];
    mem_raddr    = ptr_q[IdxW-1:0];
    mem_wdata    = sweep_data_q;
    lp           = ptr_q;
    lp_nx        = ptr_q;
    bp           = bit_q;
    bp_nx        = {1'b0, bit_q};
    slot_in      = slot_q;
    slot_nx      = slot_q;
    go_end       = 1'b0;

    // Sweep one store entry per cycle
    if (sweep_q) begin
      mem_we       = 1'b1;
      sweep_addr_d = sweep_addr_q + CntW'(1);
      if (sweep_addr_d == sweep_end_q) begin
        sweep_d = 1'b0;
        init_d  = 1'b0;
      end
    end

    if (fire) begin
      b_valid_d = 1'b1;
      b_d       = '0;
      b_d.hi    = duty_hi;
      b_d.lo    = duty_lo;
      unique case (head_i.mode)
        MODE_WRITE_ONE: begin
          if (head_i.in_range) begin
            mem_we    = 1'b1;
            mem_waddr = IdxW'(CntW'(head_i.led_index));
            mem_wdata = head_i.color;
          end
          b_d.accepted = head_i.in_range;
        end
        MODE_WRITE_ALL: begin
          if (eff_count_i != '0) begin
            sweep_d      = 1'b1;
            sweep_addr_d = '0;
            sweep_end_d  = eff_count_i;
            sweep_data_d = head_i.color;
          end
          b_d.accepted = 1'b1;
        end
        MODE_START: begin
          if (!busy_q) begin
            busy_d       = 1'b1;
            phase_d      = PH_START;
            slot_d       = '0;
            ptr_d        = '0;
            bit_d        = '0;
            b_d.accepted = 1'b1;
          end
        end
        MODE_TICK: begin
          if (busy_q) begin
            b_d.duty_valid = 1'b1;
            if (phase_q == PH_START) begin
              // Start reset pulse: one half-period slot, then zeros
              b_d.fix = (slot_q == 8'd0) ? duty_half : 16'd0;
              slot_nx = slot_q + 8'd1;
              if (slot_nx >= slots_eff) begin
                slot_d  = '0;
                ptr_d   = '0;
                bit_d   = '0;
                phase_d = (eff_count_i == '0) ? PH_END : PH_DATA;
              end else begin
                slot_d = slot_nx;
              end
            end else begin
              go_end = 1'b1;
              if (phase_q == PH_DATA) begin
                // Skip to the next LED if the bit position already ran past
                if ({1'b0, bp} >= nbits) begin
                  bp = '0;
                  lp = lp + CntW'(1);
                end
                if (lp >= eff_count_i) begin
                  phase_d = PH_END;
                  slot_in = '0;
                  ptr_d   = lp;
                  bit_d   = bp;
                end else begin
                  // Data slot: read the LED word, pick the bit on the way out
                  go_end    = 1'b0;
                  mem_re    = 1'b1;
                  mem_raddr = lp[IdxW-1:0];
                  b_d.use_mem = 1'b1;
                  b_d.bsel    = bp;
                  bp_nx       = {1'b0, bp} + 6'd1;
                  if (bp_nx >= nbits) begin
                    lp_nx = lp + CntW'(1);
                    bit_d = '0;
                    ptr_d = lp_nx;
                    if (lp_nx >= eff_count_i) begin
                      phase_d = PH_END;
                      slot_d  = '0;
                    end
                  end else begin
                    bit_d = bp_nx[4:0];
                    ptr_d = lp;
                  end
                end
              end
              if (go_end) begin
                // End reset pulse: zero slots, then drop busy
                slot_nx = slot_in + 8'd1;
                if (slot_nx >= slots_eff) begin
                  b_d.done = 1'b1;
                  busy_d   = 1'b0;
                  phase_d  = PH_IDLE;
                  slot_d   = '0;
                  ptr_d    = '0;
                  bit_d    = '0;
                end else begin
                  slot_d = slot_nx;
                end
              end
            end
          end
        end
      endcase
      b_d.busy = busy_d;
    end
  end

  // Sequencer state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      busy_q       <= 1'b0;
      ptr_q        <= '0;
      bit_q        <= '0;
      slot_q       <= '0;
      init_q       <= 1'b1;
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      sweep_end_q  <= CntW'(MAX_LEDS);
      sweep_data_q <= '0;
      b_valid_q    <= 1'b0;
      b_q          <= '0;
    end else begin
      phase_q      <= phase_d;
      busy_q       <= busy_d;
      ptr_q        <= ptr_d;
      bit_q        <= bit_d;
      slot_q       <= slot_d;
      init_q       <= init_d;
      sweep_q      <= sweep_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      sweep_data_q <= sweep_data_d;
      b_valid_q    <= b_valid_d;
      b_q          <= b_d;
    end
  end

  // Color store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Drive the result beat
  assign result.valid           = b_valid_q;
  assign result.data.accepted   = b_q.accepted;
  assign result.data.duty_valid = b_q.duty_valid;
  assign result.data.busy_res   = b_q.busy;
  assign result.data.frame_done = b_q.done;
  assign result.data.duty       = !b_q.use_mem ? b_q.fix :
                                  (rdata_q[5'd31 - b_q.bsel] ? b_q.hi : b_q.lo);

endmodule

`default_nettype wire

FILE: rtl/core/rgbw_led_strip_pwm_encoder.sv
`default_nettype none

// RGBW LED strip PWM bit encoder. Input beats write one LED, write all LEDs,
// start a frame or tick one PWM slot; every input beat yields exactly one result
// beat, in order. Each accepted beat passes through the command queue and is
// executed into the registered result stage, so beats flow at one per cycle
// when the output is not stalled and no store sweep is running. A write-all
// fills the color store through its single write port, one LED per cycle, so
// the command after it waits until the sweep has covered min(led_count,
// MAX_LEDS) entries; the input keeps filling the two-entry command queue
// meanwhile. After reset the store is cleared in a pass over all MAX_LEDS
// entries during which the input is not ready; configuration writes are taken
// at any time and must only be issued while no beat is queued or waiting in the
// result stage; a frame in progress picks up the new values on its next slot.

`include "rgbw_led_strip_pwm_encoder_assert.svh"

module rgbw_led_strip_pwm_encoder #(
  parameter int unsigned MAX_LEDS = rgbw_enc_pkg::MAX_LEDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgbw_enc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgbw_enc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rgbw_enc_in_if.sink                         item_i,
  rgbw_enc_out_if.source                      result_o
);
  import rgbw_enc_pkg::*;

  localparam int unsigned CntW = (MAX_LEDS + 1 > 512) ? $clog2(MAX_LEDS + 1) : 9;

  cfg_t            cfg_q;
  logic [CntW-1:0] eff_count;
  status_t         status;
  logic            push, pop, q_empty, q_full;
  cmd_t            push_cmd, head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{period: PERIOD_RST, use_white: USE_WHITE_RST,
                 reset_slots: RESET_SLOTS_RST, led_count: LED_COUNT_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD:      cfg_q.period      <= cfg_data_i;
        CFG_USE_WHITE:   cfg_q.use_white   <= cfg_data_i[0];
        CFG_RESET_SLOTS: cfg_q.reset_slots <= cfg_data_i[7:0];
        CFG_LED_COUNT:   cfg_q.led_count   <= cfg_data_i[8:0];
      endcase
    end
  end

  // Clamp the LED count to the store depth
  assign eff_count = (CntW'(cfg_q.led_count) < CntW'(MAX_LEDS)) ?
                     CntW'(cfg_q.led_count) : CntW'(MAX_LEDS);

  rgbw_enc_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .item        (item_i),
    .status_i    (status),
    .eff_count_i (eff_count),
    .full_i      (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  rgbw_enc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  rgbw_enc_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .eff_count_i (eff_count),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .status_o    (status),
    .result      (result_o)
  );

  `RLS_ASSERT_NEXT(a_clear_once, clk_i, rst_ni, !status.clearing, !status.clearing, "store clear pass restarted")
  `RLS_ASSERT_IMP(a_no_beat_in_clear, clk_i, rst_ni, item_i.valid && item_i.ready, !status.clearing, "input beat taken during clear pass")
  `RLS_ASSERT_IMP(a_done_ends_frame, clk_i, rst_ni, result_o.valid && result_o.data.frame_done, !result_o.data.busy_res && result_o.data.duty_valid, "frame end with busy still set")
  `RLS_ASSERT_IMP(a_slot_not_accept, clk_i, rst_ni, result_o.valid && result_o.data.duty_valid, !result_o.data.accepted, "slot beat flagged as accepted")

endmodule

`default_nettype wire
